// ----- src/multi_dfa_tokenizer_unit_defines.svh -----
// Assertion macros shared by the tokenizer RTL.
// Depends on nothing; users supply clk and rst in scope.
`ifndef MULTI_DFA_TOKENIZER_UNIT_DEFINES_SVH
`define MULTI_DFA_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MDT_ASSERT_IMPLY(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication, disabled during reset.
`define MDT_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("tokenizer assertion failed");

`endif

// ----- src/mdt_pkg.sv -----
// Package for the multi-automaton tokenizer: sizes, codes, beat structs.
// Used by the controller, datapath and top level; depends on nothing.
`timescale 1ns / 1ps

package mdt_pkg;

  localparam int TABLES       = 4;
  localparam int STATES       = 16;
  localparam int TRANSITIONS  = 4;
  localparam int LIST_SYMBOLS = 8;
  localparam int TOKEN_LENGTH = 32;

  localparam int TBL_W   = $clog2(TABLES);
  localparam int ST_W    = $clog2(STATES);
  localparam int TXT_AW  = $clog2(TOKEN_LENGTH);
  localparam int LEN_W   = TXT_AW + 1;
  localparam int SYM_W   = 21;
  localparam int TR_W    = 9;

  // Item kinds.
  localparam logic [2:0] KIND_SYM   = 3'd0;
  localparam logic [2:0] KIND_EOT   = 3'd1;
  localparam logic [2:0] KIND_HDR   = 3'd2;
  localparam logic [2:0] KIND_COUNT = 3'd3;
  localparam logic [2:0] KIND_TRANS = 3'd4;
  localparam logic [2:0] KIND_LIST  = 3'd5;

  // Result classes.
  localparam logic [1:0] CLASS_NIL   = 2'd0;
  localparam logic [1:0] CLASS_END   = 2'd1;
  localparam logic [1:0] CLASS_TOKEN = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [20:0] symbol;
    logic [1:0]  table_sel;
    logic [3:0]  state_sel;
    logic [1:0]  slot_sel;
    logic [2:0]  position_sel;
    logic [3:0]  target_state;
    logic        allow_listed;
    logic [3:0]  entry_count;
    logic [4:0]  state_count;
    logic [7:0]  type_code;
  } in_t;

  typedef struct packed {
    logic [1:0]  token_class;
    logic [1:0]  source_table;
    logic [7:0]  token_code;
    logic [20:0] text_symbol;
    logic        text_valid;
    logic        truncated;
    logic        last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_NIL,
    ST_END
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic fire;
    logic lookup;
    logic step;
    logic tbl_inc;
    logic emit_rd;
    logic emit_ld;
    logic ld_nil;
    logic ld_end;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [2:0] kind;
    logic       used_zero;
    logic       consumed;
    logic       tbl_last;
    logic       accept;
    logic       emit_last;
    logic       out_free;
  } sts_t;

endpackage

// ----- src/mdt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module mdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/mdt_ctrl.sv -----
// Controller state machine of the tokenizer.
// Depends on mdt_pkg; talks to mdt_datapath through cmd_t and sts_t.
`timescale 1ns / 1ps

module mdt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  mdt_pkg::sts_t sts,
  output mdt_pkg::cmd_t cmd
);

  mdt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      mdt_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (sts.kind == mdt_pkg::KIND_SYM && !sts.used_zero) begin
            state_next = mdt_pkg::ST_LOOKUP;
          end else if (sts.kind == mdt_pkg::KIND_EOT) begin
            state_next = sts.consumed ? mdt_pkg::ST_NIL : mdt_pkg::ST_END;
          end
        end
      end
      mdt_pkg::ST_LOOKUP: state_next = mdt_pkg::ST_DECIDE;
      mdt_pkg::ST_DECIDE: begin
        if (sts.accept) begin
          state_next = mdt_pkg::ST_EMIT_RD;
        end else if (sts.tbl_last) begin
          state_next = mdt_pkg::ST_IDLE;
        end else begin
          state_next = mdt_pkg::ST_LOOKUP;
        end
      end
      mdt_pkg::ST_EMIT_RD: state_next = mdt_pkg::ST_EMIT_LD;
      mdt_pkg::ST_EMIT_LD: begin
        if (sts.out_free) begin
          state_next = sts.emit_last ? mdt_pkg::ST_IDLE : mdt_pkg::ST_EMIT_RD;
        end
      end
      mdt_pkg::ST_NIL: begin
        if (sts.out_free) begin
          state_next = mdt_pkg::ST_END;
        end
      end
      mdt_pkg::ST_END: begin
        if (sts.out_free) begin
          state_next = mdt_pkg::ST_IDLE;
        end
      end
      default: state_next = mdt_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      mdt_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        cmd.fire   = item_valid;
      end
      mdt_pkg::ST_LOOKUP: cmd.lookup = 1'b1;
      mdt_pkg::ST_DECIDE: begin
        cmd.step    = 1'b1;
        cmd.tbl_inc = !sts.accept && !sts.tbl_last;
      end
      mdt_pkg::ST_EMIT_RD: cmd.emit_rd = 1'b1;
      mdt_pkg::ST_EMIT_LD: cmd.emit_ld = sts.out_free;
      mdt_pkg::ST_NIL:     cmd.ld_nil  = sts.out_free;
      mdt_pkg::ST_END:     cmd.ld_end  = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ----- src/mdt_datapath.sv -----
// Datapath of the tokenizer: table stores, automaton state, text buffer, output register.
// Depends on mdt_pkg and mdt_ram; driven by mdt_ctrl through cmd_t.
`timescale 1ns / 1ps

module mdt_datapath (
  input  logic          clk,
  input  logic          rst,
  input  mdt_pkg::in_t  item,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_data,
  input  mdt_pkg::cmd_t cmd,
  output mdt_pkg::sts_t sts,
  output logic          result_valid,
  input  logic          result_ready,
  output mdt_pkg::out_t result
);

  localparam int RAW   = mdt_pkg::TBL_W + mdt_pkg::ST_W;
  localparam int TAW   = mdt_pkg::TBL_W + mdt_pkg::TXT_AW;
  localparam int LEN_W = mdt_pkg::LEN_W;

  // Configuration and per-table state.
  logic [2:0] tables_in_use;
  logic [2:0] used;
  logic [4:0] tbl_size   [mdt_pkg::TABLES];
  logic [7:0] table_type [mdt_pkg::TABLES];
  logic [mdt_pkg::ST_W-1:0]  scan_state [mdt_pkg::TABLES];
  logic [mdt_pkg::LEN_W-1:0] txt_len    [mdt_pkg::TABLES];
  logic                      ovf        [mdt_pkg::TABLES];
  logic                      consumed;

  // Scan and emit bookkeeping.
  logic [20:0]                sym;
  logic [mdt_pkg::TBL_W-1:0]  tbl;
  logic [mdt_pkg::TXT_AW-1:0] kidx;
  logic [mdt_pkg::TBL_W-1:0]  emit_tab;
  logic [7:0]                 emit_type;
  logic [mdt_pkg::LEN_W-1:0]  emit_len;
  logic                       emit_ovf;

  logic [RAW-1:0] waddr, raddr;
  logic [2:0]     cnt_q;
  logic [mdt_pkg::TR_W-1:0] tr_q [mdt_pkg::TRANSITIONS];
  logic [20:0] cond_q [mdt_pkg::TRANSITIONS][mdt_pkg::LIST_SYMBOLS];
  logic [20:0] txt_q;

  logic [3:0] cnt_sat, len_sat;
  logic       fire_cnt, fire_tr, fire_list;

  assign used = (tables_in_use > 3'(mdt_pkg::TABLES)) ? 3'(mdt_pkg::TABLES) : tables_in_use;
  assign waddr = {item.table_sel, item.state_sel};
  assign raddr = {tbl, scan_state[tbl]};
  assign fire_cnt  = cmd.fire && item.kind == mdt_pkg::KIND_COUNT;
  assign fire_tr   = cmd.fire && item.kind == mdt_pkg::KIND_TRANS;
  assign fire_list = cmd.fire && item.kind == mdt_pkg::KIND_LIST;
  assign cnt_sat = (item.entry_count > 4'(mdt_pkg::TRANSITIONS)) ?
                   4'(mdt_pkg::TRANSITIONS) : item.entry_count;
  assign len_sat = (item.entry_count > 4'(mdt_pkg::LIST_SYMBOLS)) ?
                   4'(mdt_pkg::LIST_SYMBOLS) : item.entry_count;

  // Transition count per state.
  mdt_ram #(.WIDTH(3), .DEPTH(mdt_pkg::TABLES * mdt_pkg::STATES)) u_cnt_ram (
    .clk(clk), .we(fire_cnt), .waddr(waddr), .wdata(cnt_sat[2:0]),
    .re(cmd.lookup), .raddr(raddr), .rdata(cnt_q)
  );

  // One transition lane and its list-symbol lanes per slot.
  for (genvar s = 0; s < mdt_pkg::TRANSITIONS; s++) begin : g_slot
    mdt_ram #(.WIDTH(mdt_pkg::TR_W), .DEPTH(mdt_pkg::TABLES * mdt_pkg::STATES)) u_tr_ram (
      .clk(clk), .we(fire_tr && item.slot_sel == 2'(s)), .waddr(waddr),
      .wdata({len_sat, item.allow_listed, item.target_state}),
      .re(cmd.lookup), .raddr(raddr), .rdata(tr_q[s])
    );
    for (genvar p = 0; p < mdt_pkg::LIST_SYMBOLS; p++) begin : g_pos
      mdt_ram #(.WIDTH(21), .DEPTH(mdt_pkg::TABLES * mdt_pkg::STATES)) u_cond_ram (
        .clk(clk),
        .we(fire_list && item.slot_sel == 2'(s) && item.position_sel == 3'(p)),
        .waddr(waddr), .wdata(item.symbol),
        .re(cmd.lookup), .raddr(raddr), .rdata(cond_q[s][p])
      );
    end
  end

  // Next state: all list compares in parallel, then first matching slot.
  logic [mdt_pkg::TRANSITIONS-1:0] hit;
  logic [mdt_pkg::ST_W-1:0]        nx;
  always_comb begin
    logic found;
    for (int s = 0; s < mdt_pkg::TRANSITIONS; s++) begin
      found = 1'b0;
      for (int p = 0; p < mdt_pkg::LIST_SYMBOLS; p++) begin
        if (4'(p) < tr_q[s][8:5] && cond_q[s][p] == sym) begin
          found = 1'b1;
        end
      end
      hit[s] = (3'(s) < cnt_q) && (found == tr_q[s][4]);
    end
    nx = '0;
    for (int s = mdt_pkg::TRANSITIONS - 1; s >= 0; s--) begin
      if (hit[s]) begin
        nx = tr_q[s][3:0];
      end
    end
  end

  // Text and overflow update for the table under scan.
  logic [mdt_pkg::LEN_W-1:0] len_upd;
  logic                      ovf_upd, txt_we, accept;
  always_comb begin
    len_upd = txt_len[tbl];
    ovf_upd = ovf[tbl];
    txt_we  = 1'b0;
    if (nx == '0) begin
      if (scan_state[tbl] != '0) begin
        len_upd = '0;
        ovf_upd = 1'b0;
      end
    end else if (txt_len[tbl] < LEN_W'(mdt_pkg::TOKEN_LENGTH)) begin
      len_upd = txt_len[tbl] + 1'b1;
      txt_we  = cmd.step;
    end else begin
      ovf_upd = 1'b1;
    end
    accept = (tbl_size[tbl] != '0) && ({1'b0, nx} == tbl_size[tbl] - 5'd1);
  end

  // Text buffer, one row per table.
  mdt_ram #(.WIDTH(21), .DEPTH(mdt_pkg::TABLES << mdt_pkg::TXT_AW)) u_txt_ram (
    .clk(clk), .we(txt_we),
    .waddr(TAW'({tbl, txt_len[tbl][mdt_pkg::TXT_AW-1:0]})), .wdata(sym),
    .re(cmd.emit_rd), .raddr(TAW'({emit_tab, kidx})), .rdata(txt_q)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tables_in_use <= '0;
      consumed      <= 1'b0;
      for (int t = 0; t < mdt_pkg::TABLES; t++) begin
        scan_state[t] <= '0;
        txt_len[t]    <= '0;
        ovf[t]        <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        tables_in_use <= cfg_data;
      end
      if (cmd.fire && item.kind == mdt_pkg::KIND_SYM) begin
        consumed <= 1'b1;
      end
      if (cmd.fire && item.kind == mdt_pkg::KIND_HDR) begin
        scan_state[item.table_sel] <= '0;
        txt_len[item.table_sel]    <= '0;
        ovf[item.table_sel]        <= 1'b0;
      end
      if (cmd.step) begin
        if (accept) begin
          scan_state[tbl] <= '0;
          txt_len[tbl]    <= '0;
          ovf[tbl]        <= 1'b0;
          consumed        <= 1'b0;
        end else begin
          scan_state[tbl] <= nx;
          txt_len[tbl]    <= len_upd;
          ovf[tbl]        <= ovf_upd;
        end
      end
      if (cmd.ld_nil) begin
        consumed <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      sym <= item.symbol;
      tbl <= '0;
    end
    if (cmd.fire && item.kind == mdt_pkg::KIND_HDR) begin
      tbl_size[item.table_sel]   <= item.state_count;
      table_type[item.table_sel] <= item.type_code;
    end
    if (cmd.tbl_inc) begin
      tbl <= tbl + 1'b1;
    end
    if (cmd.step && accept) begin
      emit_tab  <= tbl;
      emit_type <= table_type[tbl];
      emit_len  <= len_upd;
      emit_ovf  <= ovf_upd;
      kidx      <= '0;
    end
    if (cmd.emit_ld) begin
      kidx <= kidx + 1'b1;
    end
  end

  // Output register.
  logic emit_last;
  assign emit_last = (LEN_W'(kidx) + 1'b1) >= emit_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_ld || cmd.ld_nil || cmd.ld_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      result.token_class  <= mdt_pkg::CLASS_TOKEN;
      result.source_table <= emit_tab;
      result.token_code   <= emit_type;
      result.text_symbol  <= (emit_len == '0) ? '0 : txt_q;
      result.text_valid   <= (emit_len != '0);
      result.truncated    <= emit_ovf;
      result.last         <= emit_last;
    end else if (cmd.ld_nil || cmd.ld_end) begin
      result.token_class  <= cmd.ld_nil ? mdt_pkg::CLASS_NIL : mdt_pkg::CLASS_END;
      result.source_table <= '0;
      result.token_code   <= '0;
      result.text_symbol  <= '0;
      result.text_valid   <= 1'b0;
      result.truncated    <= 1'b0;
      result.last         <= 1'b1;
    end
  end

  // Status.
  assign sts.kind      = item.kind;
  assign sts.used_zero = (used == '0);
  assign sts.consumed  = consumed;
  assign sts.tbl_last  = (3'(tbl) + 3'd1 >= used);
  assign sts.accept    = accept;
  assign sts.emit_last = emit_last;
  assign sts.out_free  = !result_valid || result_ready;

endmodule

// ----- src/multi_dfa_tokenizer_unit.sv -----
// Top level of the multi-automaton tokenizer: controller plus datapath.
// Depends on mdt_pkg, mdt_ctrl, mdt_datapath and the assertion header.
//
// Usage: items arrive on item/item_valid/item_ready, results leave on
// result/result_valid/result_ready; a beat moves when valid and ready are high.
// Load items (header, transition count, transition, list symbol) are taken in
// idle and give no result. cfg_we/cfg_data must write tables_in_use only while
// idle; the block does not enforce it. Per table visited, a lookup state reads
// the table store and a decide state does the parallel list compare and state
// update. Per text beat of an accepting table, an emit-read state reads the text
// buffer's registered read port and an emit-load state stalls on result_ready.
// End of text gives one or two beats, one per cycle if the receiver takes them.
// The block takes a new item only when the previous one is done; a finished
// beat may still sit in the output register while the next item is taken.
// Reset clears the automaton states, text lengths, flags and tables_in_use;
// the table stores keep their contents and must be loaded before scanning.
`timescale 1ns / 1ps
`include "multi_dfa_tokenizer_unit_defines.svh"

module multi_dfa_tokenizer_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  mdt_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_ready,
  output mdt_pkg::out_t result,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_data
);

  mdt_pkg::cmd_t cmd;
  mdt_pkg::sts_t sts;

  mdt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_ready(item_ready),
    .sts(sts), .cmd(cmd)
  );

  mdt_datapath u_datapath (
    .clk(clk), .rst(rst), .item(item), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts), .result_valid(result_valid),
    .result_ready(result_ready), .result(result)
  );

  // A text beat only belongs to a table token.
  `MDT_ASSERT_IMPLY(a_text_in_token, result_valid && result.text_valid, result.token_class == mdt_pkg::CLASS_TOKEN)
  // Nil and end beats are always single-beat runs.
  `MDT_ASSERT_IMPLY(a_marker_last, result_valid && result.token_class != mdt_pkg::CLASS_TOKEN, result.last)
  // End of text always yields a result, so the block is busy next cycle.
  `MDT_ASSERT_NEXT(a_eot_busy, item_valid && item_ready && item.kind == mdt_pkg::KIND_EOT, !item_ready)

endmodule
